// ----- rtl/mdi_pkg.sv -----
package mdi_pkg;

  // Transaction kinds
  localparam logic [1:0] KIND_APPLY  = 2'd0;
  localparam logic [1:0] KIND_ARM    = 2'd1;
  localparam logic [1:0] KIND_DISARM = 2'd2;

  // Drive modes reported with each result
  localparam logic [1:0] MODE_COMPARE = 2'd0;
  localparam logic [1:0] MODE_LOW     = 2'd1;
  localparam logic [1:0] MODE_KEEP    = 2'd2;

  // Interlock phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_COAST = 2'd1;
  localparam logic [1:0] PH_SETUP = 2'd2;

  // Direction codes, two's complement of -1/0/+1
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b11;

  // Configuration register indexes
  localparam logic [2:0] REG_PERIOD  = 3'd0;
  localparam logic [2:0] REG_LIMIT   = 3'd1;
  localparam logic [2:0] REG_REVMASK = 3'd2;
  localparam logic [2:0] REG_COAST   = 3'd3;
  localparam logic [2:0] REG_SETUP   = 3'd4;
  localparam logic [2:0] REG_SAFE    = 3'd5;

  localparam int CFG_W = 23;

  // Percent scale and its reciprocal: floor(x / 100) = (x * RECIP_100) >> 32
  // for every x below 2^23.
  localparam logic [6:0]  PCT_SCALE   = 7'd100;
  localparam logic [25:0] RECIP_100   = 26'd42949673;
  localparam int          RECIP_SHIFT = 32;

  // Per-channel interlock state held in the state memory
  typedef struct packed {
    logic [1:0]  settled;
    logic [1:0]  pending;
    logic [1:0]  phase;
    logic [31:0] t0;
  } chan_st_t;

  // Interlock decision for one apply transaction
  typedef struct packed {
    logic ready;
    logic pin_we;
    logic pin_val;
  } il_res_t;

  // Result payload as it moves down the pipeline
  typedef struct packed {
    logic        out_channel;
    logic        direction_pin;
    logic [1:0]  drive_mode;
    logic [16:0] compare_value;
    logic [7:0]  applied_pwm;
    logic [1:0]  phase;
    logic        is_armed;
    logic        calc;
    logic [6:0]  duty;
  } res_t;

endpackage

// ----- rtl/mdi_ram.sv -----
module mdi_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 2
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mdi_interlock.sv -----
module mdi_interlock (
  input  mdi_pkg::chan_st_t  st_i,
  input  logic [1:0]         req_i,
  input  logic [31:0]        now_i,
  input  logic signed [23:0] speed_i,
  input  logic               speed_ok_i,
  input  logic [15:0]        coast_i,
  input  logic [15:0]        setup_i,
  input  logic [22:0]        safe_i,
  output mdi_pkg::chan_st_t  st_o,
  output mdi_pkg::il_res_t   res_o
);
  import mdi_pkg::*;

  logic [31:0] coast_t0;
  logic [31:0] coast_el;
  logic [31:0] setup_el;
  logic [23:0] speed_u;
  logic [23:0] mag;
  logic        req_fwd;

  // Elapsed times and speed magnitude
  assign coast_t0 = (req_i != st_i.pending) ? now_i : st_i.t0;
  assign coast_el = now_i - coast_t0;
  assign setup_el = now_i - st_i.t0;
  assign speed_u  = unsigned'(speed_i);
  assign mag      = speed_u[23] ? (~speed_u + 24'd1) : speed_u;
  assign req_fwd  = (req_i == DIR_FWD);

  // Idle / coast / setup interlock step
  always_comb begin
    st_o  = st_i;
    res_o = '0;
    if (req_i == DIR_NONE) begin
      st_o          = '0;
      res_o.pin_we  = 1'b1;
      res_o.pin_val = 1'b0;
    end else begin
      case (st_i.phase)
        PH_SETUP: begin
          if (req_i != st_i.pending) begin
            res_o.pin_we  = 1'b1;
            res_o.pin_val = req_fwd;
            st_o.pending  = req_i;
            st_o.t0       = now_i;
          end else if (setup_el >= {16'd0, setup_i}) begin
            // t0 is left as is once settled
            st_o.settled = req_i;
            st_o.pending = DIR_NONE;
            st_o.phase   = PH_IDLE;
            res_o.ready  = 1'b1;
          end
        end
        PH_COAST: begin
          if (req_i == st_i.settled) begin
            st_o.pending  = DIR_NONE;
            st_o.phase    = PH_IDLE;
            st_o.t0       = '0;
            res_o.pin_we  = 1'b1;
            res_o.pin_val = (st_i.settled == DIR_FWD);
            res_o.ready   = 1'b1;
          end else begin
            st_o.pending = req_i;
            st_o.t0      = coast_t0;
            if (coast_el >= {16'd0, coast_i} && speed_ok_i && mag <= {1'b0, safe_i}) begin
              res_o.pin_we  = 1'b1;
              res_o.pin_val = req_fwd;
              st_o.phase    = PH_SETUP;
              st_o.t0       = now_i;
            end
          end
        end
        default: begin
          if (st_i.settled == DIR_NONE) begin
            res_o.pin_we  = 1'b1;
            res_o.pin_val = req_fwd;
            st_o.pending  = req_i;
            st_o.phase    = PH_SETUP;
            st_o.t0       = now_i;
          end else if (req_i != st_i.settled) begin
            st_o.pending = req_i;
            st_o.phase   = PH_COAST;
            st_o.t0      = now_i;
          end else begin
            res_o.ready = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/motor_direction_interlock_core.sv -----
// Pipeline: an accepted transaction passes the state read and update, the duty
// product and the divide by 100, then the output register, to show on out_valid.
// Throughput: one transaction per cycle unless out_stall holds it; state is in a
// one-port-write, registered-read RAM; back-to-back channel updates are forwarded.
// Reset (rst_n low, synchronous): pipeline empty, disarmed, pins low, every channel
// idle with no direction; registers zero except pwm_limit, which is 100.
module motor_direction_interlock_core #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [mdi_pkg::CFG_W-1:0]   cfg_wdata,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic                        in_channel,
  input  logic signed [15:0]          in_requested_pwm,
  input  logic [31:0]                 in_now_ms,
  input  logic signed [23:0]          in_measured_speed,
  input  logic                        in_speed_valid,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_channel,
  output logic                        out_direction_pin,
  output logic [1:0]                  out_drive_mode,
  output logic [16:0]                 out_compare_value,
  output logic signed [7:0]           out_applied_pwm,
  output logic [1:0]                  out_phase,
  output logic                        out_is_armed
);
  import mdi_pkg::*;

  localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ST_W  = $bits(chan_st_t);
  localparam logic [CH_AW:0] NCH = (CH_AW + 1)'(NUM_CHANNELS);

  // configuration registers
  logic [16:0] period_r;
  logic [6:0]  limit_r;
  logic [1:0]  revmask_r;
  logic [15:0] coast_r;
  logic [15:0] setup_r;
  logic [22:0] safe_r;

  // control state outside the memory
  logic armed_r;
  logic armed_nxt;
  logic dir_pin_r [NUM_CHANNELS];
  logic ent_vld_r [NUM_CHANNELS];

  // pipeline handshake
  logic in_fire;
  logic ld1, ld2, ld3, ld_out;
  logic s1_fire;

  // stage 1: state read and update
  logic               s1_v_r;
  logic [1:0]         s1_kind_r;
  logic               s1_ch_r;
  logic signed [15:0] s1_pwm_r;
  logic [31:0]        s1_now_r;
  logic signed [23:0] s1_speed_r;
  logic               s1_svalid_r;
  logic [CH_AW-1:0]   s1_addr_r;
  logic               s1_fwd_hit_r;
  chan_st_t           s1_fwd_data_r;

  // memory ports
  logic             ram_we;
  logic [CH_AW-1:0] ram_raddr;
  logic [ST_W-1:0]  ram_rdata;
  chan_st_t         st_raw;
  chan_st_t         st_cur;
  chan_st_t         st_nxt;
  il_res_t          il_res;

  // stage 1 arithmetic
  logic               ch_ok;
  logic               apply_ok;
  logic               is_arm;
  logic               is_disarm;
  logic [6:0]         lim;
  logic signed [15:0] lim_s;
  logic signed [7:0]  clamped;
  logic signed [7:0]  cmd;
  logic signed [7:0]  raw;
  logic [1:0]         req_dir;
  logic [7:0]         raw_mag;
  logic [6:0]         duty;
  logic               pin_cur;
  res_t               s1_res;

  // stages 2 and 3
  logic        s2_v_r;
  res_t        s2_res_r;
  logic        s3_v_r;
  res_t        s3_res_r;
  logic [22:0] s3_prod_r;
  logic [48:0] q_full;
  logic [16:0] q;
  res_t        s3_res;

  // output register
  logic out_valid_r;
  res_t out_res_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= '0;
      limit_r   <= PCT_SCALE;
      revmask_r <= '0;
      coast_r   <= '0;
      setup_r   <= '0;
      safe_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PERIOD:  period_r  <= cfg_wdata[16:0];
        REG_LIMIT:   limit_r   <= cfg_wdata[6:0];
        REG_REVMASK: revmask_r <= cfg_wdata[1:0];
        REG_COAST:   coast_r   <= cfg_wdata[15:0];
        REG_SETUP:   setup_r   <= cfg_wdata[15:0];
        REG_SAFE:    safe_r    <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  // Stage load enables, back from the output
  assign ld_out   = !out_valid_r || !out_stall;
  assign ld3      = !s3_v_r || ld_out;
  assign ld2      = !s2_v_r || ld3;
  assign ld1      = !s1_v_r || ld2;
  assign in_stall = !ld1;
  assign in_fire  = in_valid && ld1;
  assign s1_fire  = s1_v_r && ld2;

  // Read address: the channel for an apply, channel 0 otherwise
  assign ram_raddr = (in_kind == KIND_APPLY) ? CH_AW'(in_channel) : '0;

  mdi_ram #(
    .WIDTH (ST_W),
    .DEPTH (NUM_CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (st_nxt),
    .re    (in_fire),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Stage 1 capture, with forwarding of a write at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (ld1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r     <= in_kind;
      s1_ch_r       <= in_channel;
      s1_pwm_r      <= in_requested_pwm;
      s1_now_r      <= in_now_ms;
      s1_speed_r    <= in_measured_speed;
      s1_svalid_r   <= in_speed_valid;
      s1_addr_r     <= ram_raddr;
      s1_fwd_hit_r  <= ram_we && (s1_addr_r == ram_raddr);
      s1_fwd_data_r <= st_nxt;
    end
  end

  // Current channel state: forwarded, stored, or reset value if unwritten or disarmed
  assign st_raw    = s1_fwd_hit_r ? s1_fwd_data_r : chan_st_t'(ram_rdata);
  assign st_cur    = ent_vld_r[s1_addr_r] ? st_raw : '0;
  assign ch_ok     = ((CH_AW + 1)'(s1_ch_r) < NCH);
  assign apply_ok  = (s1_kind_r == KIND_APPLY) && ch_ok;
  assign is_arm    = (s1_kind_r == KIND_ARM);
  assign is_disarm = (s1_kind_r == KIND_DISARM);
  assign ram_we    = s1_fire && apply_ok;

  // Clamp, arm gate and polarity
  assign lim   = (limit_r > PCT_SCALE) ? PCT_SCALE : limit_r;
  assign lim_s = signed'({9'd0, lim});
  always_comb begin
    if (s1_pwm_r > lim_s) begin
      clamped = signed'({1'b0, lim});
    end else if (s1_pwm_r < -lim_s) begin
      clamped = -signed'({1'b0, lim});
    end else begin
      clamped = s1_pwm_r[7:0];
    end
  end
  assign cmd     = armed_r ? clamped : 8'sd0;
  assign raw     = revmask_r[s1_ch_r] ? -cmd : cmd;
  assign req_dir = (raw > 8'sd0) ? DIR_FWD : ((raw < 8'sd0) ? DIR_REV : DIR_NONE);
  assign raw_mag = raw[7] ? (~unsigned'(raw) + 8'd1) : unsigned'(raw);

  mdi_interlock u_interlock (
    .st_i       (st_cur),
    .req_i      (req_dir),
    .now_i      (s1_now_r),
    .speed_i    (s1_speed_r),
    .speed_ok_i (s1_svalid_r),
    .coast_i    (coast_r),
    .setup_i    (setup_r),
    .safe_i     (safe_r),
    .st_o       (st_nxt),
    .res_o      (il_res)
  );

  assign duty      = (il_res.ready && req_dir != DIR_NONE) ? raw_mag[6:0] : 7'd0;
  assign pin_cur   = dir_pin_r[s1_addr_r];
  assign armed_nxt = is_disarm ? 1'b0 : (armed_r || (is_arm && period_r != '0));

  // Stage 1 result
  always_comb begin
    s1_res          = '0;
    s1_res.is_armed = armed_nxt;
    s1_res.drive_mode = MODE_KEEP;
    if (is_arm || is_disarm) begin
      s1_res.drive_mode    = MODE_LOW;
      s1_res.compare_value = period_r;
      s1_res.phase         = is_disarm ? PH_IDLE : st_cur.phase;
    end else if (s1_kind_r == KIND_APPLY) begin
      s1_res.out_channel = s1_ch_r;
      if (ch_ok) begin
        s1_res.direction_pin = il_res.pin_we ? il_res.pin_val : pin_cur;
        s1_res.phase         = st_nxt.phase;
        s1_res.duty          = duty;
        if (duty != '0) begin
          s1_res.applied_pwm = cmd;
        end
        if (period_r != '0) begin
          s1_res.compare_value = period_r;
          if (duty == '0) begin
            s1_res.drive_mode = MODE_LOW;
          end else begin
            s1_res.drive_mode = MODE_COMPARE;
            s1_res.calc       = 1'b1;
          end
        end
      end
    end else begin
      s1_res.direction_pin = pin_cur;
      s1_res.phase         = st_cur.phase;
    end
  end

  // Armed flag, direction pins and entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        dir_pin_r[i] <= 1'b0;
        ent_vld_r[i] <= 1'b0;
      end
    end else if (s1_fire) begin
      armed_r <= armed_nxt;
      if (is_arm || is_disarm) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          dir_pin_r[i] <= 1'b0;
        end
      end
      if (is_disarm) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          ent_vld_r[i] <= 1'b0;
        end
      end
      if (apply_ok) begin
        ent_vld_r[s1_addr_r] <= 1'b1;
        if (il_res.pin_we) begin
          dir_pin_r[s1_addr_r] <= il_res.pin_val;
        end
      end
    end
  end

  // Stage 2: period * duty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (ld2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_res_r <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (ld3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && ld3) begin
      s3_res_r  <= s2_res_r;
      s3_prod_r <= 23'(s2_res_r.compare_value) * 23'(s2_res_r.duty);
    end
  end

  // Stage 3: divide by 100 through the reciprocal, then subtract
  assign q_full = 49'(s3_prod_r) * 49'(RECIP_100);
  assign q      = q_full[RECIP_SHIFT +: 17];
  always_comb begin
    s3_res = s3_res_r;
    if (s3_res_r.calc) begin
      s3_res.compare_value = s3_res_r.compare_value - q;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && ld_out) begin
      out_res_r <= s3_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel       = out_res_r.out_channel;
  assign out_direction_pin = out_res_r.direction_pin;
  assign out_drive_mode    = out_res_r.drive_mode;
  assign out_compare_value = out_res_r.compare_value;
  assign out_applied_pwm   = signed'(out_res_r.applied_pwm);
  assign out_phase         = out_res_r.phase;
  assign out_is_armed      = out_res_r.is_armed;

`ifndef SYNTHESIS
  // a disarm clears the entry valid bit and direction pin of channel 0
  a_disarm_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && is_disarm) |=> (ent_vld_r[0] == 1'b0 && dir_pin_r[0] == 1'b0))
    else $error("disarm did not clear channel state");

  // timer drive always comes with a nonzero applied command
  a_compare_has_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drive_mode == MODE_COMPARE) |-> (out_applied_pwm != 8'sd0))
    else $error("compare drive with zero applied pwm");

  // state is not updated while the pipeline behind it is full and stalled
  a_no_update_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s3_v_r && out_valid_r && out_stall) |-> !s1_fire)
    else $error("state update while pipeline is blocked");
`endif

endmodule

// ----- bench/tb_motor_direction_interlock_core.sv -----
`timescale 1ns / 1ps

module tb_motor_direction_interlock_core;
  import mdi_pkg::*;

  // kind 3 is not decoded by the block; it only reports channel 0 status
  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam int NCH = 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 80;

  typedef struct packed {
    logic [1:0]         kind;
    logic               channel;
    logic signed [15:0] pwm;
    logic [31:0]        now;
    logic signed [23:0] speed;
    logic               speed_ok;
  } command_t;

  typedef struct packed {
    logic               channel;
    logic               pin;
    logic [1:0]         mode;
    logic [16:0]        compare;
    logic signed [7:0]  applied;
    logic [1:0]         phase;
    logic               armed;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind = KIND_APPLY;
  logic               in_channel = 1'b0;
  logic signed [15:0] in_requested_pwm = '0;
  logic [31:0]        in_now_ms = '0;
  logic signed [23:0] in_measured_speed = '0;
  logic               in_speed_valid = 1'b0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_channel;
  logic               out_direction_pin;
  logic [1:0]         out_drive_mode;
  logic [16:0]        out_compare_value;
  logic signed [7:0]  out_applied_pwm;
  logic [1:0]         out_phase;
  logic               out_is_armed;

  motor_direction_interlock_core #(.NUM_CHANNELS(NCH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_channel        (in_channel),
    .in_requested_pwm  (in_requested_pwm),
    .in_now_ms         (in_now_ms),
    .in_measured_speed (in_measured_speed),
    .in_speed_valid    (in_speed_valid),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel       (out_channel),
    .out_direction_pin (out_direction_pin),
    .out_drive_mode    (out_drive_mode),
    .out_compare_value (out_compare_value),
    .out_applied_pwm   (out_applied_pwm),
    .out_phase         (out_phase),
    .out_is_armed      (out_is_armed)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: registers and per-channel interlock
  // ---------------------------------------------------------------------------
  logic [16:0] period_r;
  logic [6:0]  limit_r;
  logic [1:0]  revmask_r;
  logic [15:0] coast_r;
  logic [15:0] setup_r;
  logic [22:0] safe_r;
  logic        armed_r;
  logic [1:0]  settled_r [NCH];
  logic [1:0]  pending_r [NCH];
  logic [1:0]  phase_r   [NCH];
  logic [31:0] t0_r      [NCH];
  logic        pin_r     [NCH];

  // Bench bookkeeping
  command_t command_q [$];
  drive_t   expected_drive_q [$];
  command_t offered_cmd;
  drive_t   head_drive;
  logic     offering = 1'b0;
  logic     in_taken = 1'b0;
  logic     out_taken = 1'b0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       long_hold = 0;
  int       next_hold_at = 120;
  int       in_gap_max = 0;
  int       out_gap_max = 0;
  int       items_queued = 0;
  int       items_taken = 0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       cycle_count = 0;
  int       settings_count = 0;
  int       compare_drives = 0;
  int       coast_results = 0;
  int       setup_results = 0;
  int       holds_done = 0;
  int       heading [NCH] = '{1, 1};
  logic [31:0] clock_ms = '0;

  function automatic void reset_model();
    period_r  = '0;
    limit_r   = 7'd100;
    revmask_r = '0;
    coast_r   = '0;
    setup_r   = '0;
    safe_r    = '0;
    armed_r   = 1'b0;
    for (int c = 0; c < NCH; c++) begin
      settled_r[c] = DIR_NONE;
      pending_r[c] = DIR_NONE;
      phase_r[c]   = PH_IDLE;
      t0_r[c]      = '0;
      pin_r[c]     = 1'b0;
    end
  endfunction

  function automatic void clear_channel(int c);
    pending_r[c] = DIR_NONE;
    phase_r[c]   = PH_IDLE;
    t0_r[c]      = '0;
  endfunction

  // Interlock step for one channel; returns 1 when the wanted direction may drive
  function automatic logic direction_ready(int c, logic [1:0] dir, logic [31:0] now,
                                           logic signed [23:0] speed, logic ok);
    int mag;
    mag = (speed < 0) ? -int'(speed) : int'(speed);
    if (dir == DIR_NONE) begin
      clear_channel(c);
      settled_r[c] = DIR_NONE;
      pin_r[c] = 1'b0;
      return 1'b0;
    end
    if (phase_r[c] == PH_SETUP) begin
      if (dir != pending_r[c]) begin
        pin_r[c] = (dir == DIR_FWD);
        pending_r[c] = dir;
        t0_r[c] = now;
        return 1'b0;
      end
      if ((now - t0_r[c]) < {16'd0, setup_r}) return 1'b0;
      settled_r[c] = dir;
      pending_r[c] = DIR_NONE;
      phase_r[c] = PH_IDLE;
      return 1'b1;
    end
    if (phase_r[c] == PH_COAST) begin
      // back to the settled direction cancels the reversal
      if (dir == settled_r[c]) begin
        clear_channel(c);
        pin_r[c] = (settled_r[c] == DIR_FWD);
        return 1'b1;
      end
      if (dir != pending_r[c]) begin
        pending_r[c] = dir;
        t0_r[c] = now;
      end
      if ((now - t0_r[c]) < {16'd0, coast_r}) return 1'b0;
      if (!ok || mag > int'(safe_r)) return 1'b0;
      pin_r[c] = (dir == DIR_FWD);
      phase_r[c] = PH_SETUP;
      t0_r[c] = now;
      return 1'b0;
    end
    // idle: from no direction go straight to setup, a reversal coasts first
    if (settled_r[c] == DIR_NONE) begin
      pin_r[c] = (dir == DIR_FWD);
      pending_r[c] = dir;
      phase_r[c] = PH_SETUP;
      t0_r[c] = now;
      return 1'b0;
    end
    if (dir != settled_r[c]) begin
      pending_r[c] = dir;
      phase_r[c] = PH_COAST;
      t0_r[c] = now;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic drive_t predict_drive(command_t cmd);
    drive_t     d;
    int         lim;
    int         pwm;
    int         raw;
    int         duty;
    logic [1:0] dir;
    logic       ready;
    d = '0;
    d.mode = MODE_KEEP;
    if (cmd.kind == KIND_ARM || cmd.kind == KIND_DISARM) begin
      for (int c = 0; c < NCH; c++) pin_r[c] = 1'b0;
      if (cmd.kind == KIND_ARM) begin
        if (period_r != '0) armed_r = 1'b1;
      end else begin
        armed_r = 1'b0;
        for (int c = 0; c < NCH; c++) begin
          settled_r[c] = DIR_NONE;
          clear_channel(c);
        end
      end
      d.mode = MODE_LOW;
      d.compare = period_r;
      d.phase = phase_r[0];
    end else if (cmd.kind == KIND_APPLY) begin
      lim = (limit_r > PCT_SCALE) ? int'(PCT_SCALE) : int'(limit_r);
      pwm = int'(cmd.pwm);
      if (pwm > lim) pwm = lim;
      else if (pwm < -lim) pwm = -lim;
      if (!armed_r) pwm = 0;
      raw = revmask_r[cmd.channel] ? -pwm : pwm;
      dir = (raw > 0) ? DIR_FWD : ((raw < 0) ? DIR_REV : DIR_NONE);
      ready = direction_ready(int'(cmd.channel), dir, cmd.now, cmd.speed, cmd.speed_ok);
      duty = 0;
      if (ready && dir != DIR_NONE) begin
        duty = (raw < 0) ? -raw : raw;
        d.applied = pwm[7:0];
      end
      if (period_r != '0) begin
        if (duty == 0) begin
          d.mode = MODE_LOW;
          d.compare = period_r;
        end else begin
          d.mode = MODE_COMPARE;
          d.compare = 17'(int'(period_r) - int'(period_r) * duty / int'(PCT_SCALE));
        end
      end
      d.channel = cmd.channel;
      d.pin = pin_r[cmd.channel];
      d.phase = phase_r[cmd.channel];
    end else begin
      d.pin = pin_r[0];
      d.phase = phase_r[0];
    end
    d.armed = armed_r;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one transaction at a time from command_q
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        offering = 1'b0;
        send_gap = $urandom_range(0, in_gap_max);
      end
      if (!offering && command_q.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          offered_cmd = command_q.pop_front();
          offering = 1'b1;
          in_kind           <= offered_cmd.kind;
          in_channel        <= offered_cmd.channel;
          in_requested_pwm  <= offered_cmd.pwm;
          in_now_ms         <= offered_cmd.now;
          in_measured_speed <= offered_cmd.speed;
          in_speed_valid    <= offered_cmd.speed_ok;
        end
      end
      in_valid <= offering;
    end
  end

  // Result receiver: random stall per result, plus occasional long hold-offs
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        recv_gap = $urandom_range(0, out_gap_max);
        if (results_seen >= next_hold_at) begin
          long_hold = 300;
          next_hold_at += 250;
          holds_done++;
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: predict on accepted input, compare on accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        head_drive = predict_drive(offered_cmd);
        if (head_drive.mode == MODE_COMPARE) compare_drives++;
        if (head_drive.phase == PH_COAST) coast_results++;
        if (head_drive.phase == PH_SETUP) setup_results++;
        expected_drive_q.push_back(head_drive);
        items_taken++;
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_drive_q.size() == 0) begin
          $display("%0t ns: result with no transaction pending, expected none, got channel %0d",
                   $time, out_channel);
          mismatches++;
        end else begin
          head_drive = expected_drive_q.pop_front();
          check_field("out_channel", int'(head_drive.channel), int'(out_channel));
          check_field("direction_pin", int'(head_drive.pin), int'(out_direction_pin));
          check_field("drive_mode", int'(head_drive.mode), int'(out_drive_mode));
          check_field("compare_value", int'(head_drive.compare), int'(out_compare_value));
          check_field("applied_pwm", int'(head_drive.applied), int'(out_applied_pwm));
          check_field("phase", int'(head_drive.phase), int'(out_phase));
          check_field("is_armed", int'(head_drive.armed), int'(out_is_armed));
        end
        results_seen++;
        out_taken = 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, expected_drive_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void push_cmd(logic [1:0] kind, logic ch, logic [15:0] pwm,
                                   logic [31:0] now, logic [23:0] speed, logic ok);
    command_t cmd;
    cmd.kind = kind;
    cmd.channel = ch;
    cmd.pwm = pwm;
    cmd.now = now;
    cmd.speed = speed;
    cmd.speed_ok = ok;
    command_q.push_back(cmd);
    items_queued++;
  endfunction

  // Block idle: every transaction accepted and every result seen
  task automatic wait_idle();
    while (items_taken != items_queued || expected_drive_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_PERIOD:  period_r  = value[16:0];
      REG_LIMIT:   limit_r   = value[6:0];
      REG_REVMASK: revmask_r = value[1:0];
      REG_COAST:   coast_r   = value[15:0];
      REG_SETUP:   setup_r   = value[15:0];
      REG_SAFE:    safe_r    = value[22:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [16:0] period, logic [6:0] limit, logic [1:0] mask,
                                logic [15:0] coast, logic [15:0] setup, logic [22:0] safe);
    wait_idle();
    write_reg(REG_PERIOD, CFG_W'(period));
    write_reg(REG_LIMIT, CFG_W'(limit));
    write_reg(REG_REVMASK, CFG_W'(mask));
    write_reg(REG_COAST, CFG_W'(coast));
    write_reg(REG_SETUP, CFG_W'(setup));
    write_reg(REG_SAFE, CFG_W'(safe));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // Mostly sustained commands per channel with occasional reversals, so the
  // interlock walks through coast and setup; a few arm/disarm and odd items.
  task automatic queue_random(int n);
    int          span;
    int          lim;
    int          sbound;
    int          r;
    logic [1:0]  kind;
    logic        ch;
    logic [15:0] pwm;
    logic [23:0] speed;
    logic        ok;
    span = ((coast_r > setup_r) ? int'(coast_r) : int'(setup_r)) / 2 + 2;
    lim = (limit_r > PCT_SCALE) ? int'(PCT_SCALE) : int'(limit_r);
    sbound = (safe_r > 23'd100000) ? 100000 : int'(safe_r);
    push_cmd(KIND_ARM, 1'b0, '0, clock_ms, '0, 1'b1);
    for (int i = 1; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) kind = KIND_ARM;
      else if (r < 8) kind = KIND_DISARM;
      else if (r < 9) kind = KIND_NOP;
      else kind = KIND_APPLY;
      ch = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 15) heading[ch] = -heading[ch];
      r = $urandom_range(0, 99);
      if (r < 10) pwm = '0;
      else if (r < 18) pwm = 16'($urandom);
      else pwm = 16'(heading[ch] * int'($urandom_range(1, lim + 5)));
      if ($urandom_range(0, 99) < 15) speed = 24'($urandom);
      else speed = 24'(int'($urandom_range(0, 2 * sbound + 4)) - sbound - 2);
      ok = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 99) < 4) clock_ms = $urandom;
      else clock_ms += 32'($urandom_range(0, span));
      push_cmd(kind, ch, pwm, clock_ms, speed, ok);
    end
  endtask

  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: PWM unconfigured, so arm leaves the block disarmed
    in_gap_max = 2;
    out_gap_max = 2;
    push_cmd(KIND_ARM, 1'b0, '0, 32'd0, '0, 1'b0);
    push_cmd(KIND_APPLY, 1'b0, 16'sd50, 32'd10, '0, 1'b1);
    push_cmd(KIND_NOP, 1'b1, 16'sd20, 32'd20, '0, 1'b1);

    // Limit above 100 acts as 100; channel 1 polarity inverted
    apply_settings(17'd1000, 7'd127, 2'b10, 16'd5, 16'd3, 23'd100);
    push_cmd(KIND_ARM, 1'b0, '0, 32'd1000, '0, 1'b1);
    push_cmd(KIND_APPLY, 1'b0, 16'sd60, 32'd1000, '0, 1'b1);      // none -> setup
    push_cmd(KIND_APPLY, 1'b0, 16'sd60, 32'd1002, '0, 1'b1);      // setup not elapsed
    push_cmd(KIND_APPLY, 1'b0, 16'sd60, 32'd1003, '0, 1'b1);      // settles, drives
    push_cmd(KIND_APPLY, 1'b0, 16'h7FFF, 32'd1004, '0, 1'b1);     // clamped to 100
    push_cmd(KIND_APPLY, 1'b0, 16'h8000, 32'd1005, '0, 1'b1);     // reversal -> coast
    push_cmd(KIND_APPLY, 1'b0, -16'sd40, 32'd1010, 24'h7FFFFF, 1'b0); // speed invalid
    push_cmd(KIND_APPLY, 1'b0, -16'sd40, 32'd1011, 24'h800000, 1'b1); // too fast
    push_cmd(KIND_APPLY, 1'b0, -16'sd40, 32'd1012, -24'sd100, 1'b1);  // at safe speed
    push_cmd(KIND_APPLY, 1'b0, 16'sd40, 32'd1013, '0, 1'b1);      // change during setup
    push_cmd(KIND_APPLY, 1'b0, 16'sd40, 32'd1016, '0, 1'b1);
    push_cmd(KIND_APPLY, 1'b0, -16'sd40, 32'd1017, '0, 1'b1);     // coast again
    push_cmd(KIND_APPLY, 1'b0, 16'sd40, 32'd1018, '0, 1'b1);      // back to settled
    push_cmd(KIND_APPLY, 1'b1, 16'sd30, 32'd1020, '0, 1'b1);      // inverted channel
    push_cmd(KIND_APPLY, 1'b1, 16'sd30, 32'd1023, '0, 1'b1);
    push_cmd(KIND_APPLY, 1'b1, 16'sd0, 32'd1024, '0, 1'b1);       // zero duty
    push_cmd(KIND_APPLY, 1'b1, 16'sd30, 32'hFFFFFFFE, '0, 1'b1);  // setup across wrap
    push_cmd(KIND_APPLY, 1'b1, 16'sd30, 32'd1, '0, 1'b1);
    push_cmd(KIND_NOP, 1'b0, '0, 32'd2, '0, 1'b0);
    push_cmd(KIND_DISARM, 1'b1, '0, 32'd3, '0, 1'b1);
    push_cmd(KIND_APPLY, 1'b0, 16'sd50, 32'd4, '0, 1'b1);         // disarmed -> zero
    push_cmd(KIND_ARM, 1'b0, '0, 32'd5, '0, 1'b1);
    clock_ms = 32'd10;

    // Period 65536, largest safe speed, zero intervals, no idling
    apply_settings(17'd65536, 7'd100, 2'b11, 16'd0, 16'd0, 23'h7FFFFF);
    in_gap_max = 0;
    out_gap_max = 0;
    queue_random(ITEMS_PER_PHASE);

    // Longest intervals, smallest nonzero period, zero safe speed
    apply_settings(17'd1, 7'd1, 2'b00, 16'hFFFF, 16'hFFFF, 23'd0);
    in_gap_max = 14;
    out_gap_max = 14;
    queue_random(ITEMS_PER_PHASE);

    // PWM unconfigured while armed: interlock runs, compare left unchanged
    apply_settings(17'd0, 7'd60, 2'b01, 16'd2, 16'd2, 23'd50);
    in_gap_max = 3;
    out_gap_max = 0;
    queue_random(ITEMS_PER_PHASE);

    // Zero limit
    apply_settings(17'd500, 7'd0, 2'b10, 16'd1, 16'd1, 23'd10);
    in_gap_max = 0;
    out_gap_max = 5;
    queue_random(20);

    // Random settings
    for (int p = 0; p < 3; p++) begin
      apply_settings(17'($urandom_range(1, 65536)), 7'($urandom_range(1, 127)),
                     2'($urandom_range(0, 3)), 16'($urandom_range(0, 20)),
                     16'($urandom_range(0, 20)), 23'($urandom_range(0, 300)));
      in_gap_max = (p == 1) ? 0 : 14;
      out_gap_max = (p == 2) ? 0 : 7;
      queue_random(ITEMS_PER_PHASE);
    end

    wait_idle();
    $display("Run covered %0d transactions under %0d register settings, %0d results checked.",
             items_taken, settings_count, results_seen);
    $display("Compare drives %0d, coast results %0d, setup results %0d, long output holds %0d.",
             compare_drives, coast_results, setup_results, holds_done);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
